// File: rtl/sacs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sacs_pkg: shared types and constants
// Sizes of the suffix automaton state table, row layout, op codes and the
// controller states of the common substring core.
// ============================================================================
package sacs_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ALPHABET = 26;
    localparam int NSTATES  = 2 * MAX_LEN;

    localparam int ST_W    = $clog2(NSTATES);       // state index
    localparam int COUNT_W = $clog2(NSTATES + 1);   // state count
    localparam int LEN_W   = 13;                    // depth / match length
    localparam int POS_W   = 16;                    // query position
    localparam int LET_W   = 5;                     // letter code
    localparam int OP_W    = 2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // One automaton state per memory row.
    typedef struct packed {
        logic [LEN_W-1:0]                len;
        logic [ST_W-1:0]                 link;
        logic [ALPHABET-1:0][ST_W-1:0]   nxt;
    } t_row;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISP,
        S_CLR,
        S_AWALK,
        S_AQ,
        S_AQLINK,
        S_ARWALK,
        S_ALINKP,
        S_QWALK,
        S_QFIN,
        S_OUT
    } t_state;

endpackage

// File: rtl/sacs_if.sv
`timescale 1ns / 1ps
// ============================================================================
// sacs_in_if / sacs_out_if: item channels
// Valid/ready channels for input items and result items.
// ============================================================================
interface sacs_in_if import sacs_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [LET_W-1:0] letter;

    modport source (output valid, output op, output letter, input ready);
    modport sink   (input valid, input op, input letter, output ready);
endinterface

interface sacs_out_if import sacs_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             status;
    logic [LEN_W-1:0] match_length;
    logic [LEN_W-1:0] best_length;
    logic [POS_W-1:0] best_start;

    modport source (output valid, output status, output match_length,
                    output best_length, output best_start, input ready);
    modport sink   (input valid, input status, input match_length,
                    input best_length, input best_start, output ready);
endinterface

// File: rtl/suffix_automaton_common_substring_core.sv
`timescale 1ns / 1ps
// ============================================================================
// suffix_automaton_common_substring_core: longest common substring engine
// Builds a suffix automaton of a reference string and matches query letters
// against it, tracking the longest common substring and its query start.
// ============================================================================
// Flow, transfer in to result valid: a clear goes S_DISP, S_CLR, S_OUT; a refused,
// ignored or unknown op goes S_DISP, S_OUT; a query walks suffix links in S_QWALK,
// then S_QFIN; an append walks links in S_AWALK, then S_AQ, and a clone adds S_AQLINK
// and S_ARWALK before S_ALINKP. Each walk step is one row read of the table RAM read port.
// One item at a time; the next item is accepted while a result waits.
// Reset: synchronous active low; the S_INIT state after reset then writes the root row.
module suffix_automaton_common_substring_core import sacs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacs_in_if.sink     i_in,
    sacs_out_if.source  o_out
);
    // ------------------------------------------------------------------
    // State table: one row per automaton state (transitions, link, depth)
    // ------------------------------------------------------------------
    logic            mem_we;
    logic [ST_W-1:0] mem_waddr;
    t_row            mem_wdata;
    logic            mem_re;
    logic [ST_W-1:0] mem_raddr;
    t_row            rd_row;

    sacs_row_ram #(
        .W     ($bits(t_row)),
        .DEPTH (NSTATES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_row)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [LET_W-1:0]    r_letter;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [ST_W-1:0]     r_last, n_last;
    logic [LEN_W-1:0]    r_last_len, n_last_len;
    logic [ST_W-1:0]     r_p, n_p;
    logic [LEN_W-1:0]    r_plen, n_plen;
    logic [ST_W-1:0]     r_cur, n_cur;
    logic [LEN_W-1:0]    r_cur_len, n_cur_len;
    logic [ST_W-1:0]     r_q, n_q;
    logic [ST_W-1:0]     r_r, n_r;
    logic [ST_W-1:0]     r_link, n_link;
    logic [ST_W-1:0]     r_mstate, n_mstate;
    logic [LEN_W-1:0]    r_cm, n_cm;
    logic [LEN_W-1:0]    r_long, n_long;
    logic [POS_W-1:0]    r_lstart, n_lstart;
    logic [POS_W-1:0]    r_qpos, n_qpos;
    logic                r_first, n_first;
    logic                r_status, n_status;

    logic                r_ovalid;
    logic                r_ostatus;
    logic [LEN_W-1:0]    r_omatch, r_obest;
    logic [POS_W-1:0]    r_ostart;

    // ------------------------------------------------------------------
    // Decodes used by the combinational and register blocks
    // ------------------------------------------------------------------
    logic               accept;
    logic               letter_ok;
    logic               full;
    logic [ST_W-1:0]    edge_to;
    logic               out_load;
    logic               new_best;
    logic [POS_W:0]     pos_next;

    assign accept    = i_in.valid && i_in.ready;
    assign letter_ok = (r_letter < LET_W'(ALPHABET));
    // refuse when the reference is at full length or fewer than two rows are free
    assign full      = (r_last_len >= LEN_W'(MAX_LEN))
                    || ({1'b0, r_count} + (COUNT_W+1)'(2) > (COUNT_W+1)'(NSTATES));
    assign edge_to   = rd_row.nxt[r_letter];
    assign out_load  = (r_state == S_OUT) && (!r_ovalid || o_out.ready);
    assign new_best  = (r_cm > r_long);
    assign pos_next  = {1'b0, r_qpos} + (POS_W+1)'(1);

    assign i_in.ready = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_op)
                    OP_CLEAR:  n_state = S_CLR;
                    OP_APPEND: n_state = (letter_ok && !full) ? S_AWALK : S_OUT;
                    OP_QUERY:  n_state = letter_ok ? S_QWALK : S_QFIN;
                    default:   n_state = S_OUT;
                endcase
            end
            S_CLR: n_state = S_OUT;
            S_AWALK: begin
                priority if (edge_to != '0) begin
                    n_state = S_AQ;
                end else if (r_cur == '0) begin
                    n_state = S_ALINKP;
                end else begin
                    n_state = S_AWALK;
                end
            end
            S_AQ: begin
                n_state = (rd_row.len == r_cur_len + LEN_W'(1)) ? S_ALINKP : S_AQLINK;
            end
            S_AQLINK: n_state = S_ARWALK;
            S_ARWALK: begin
                if (edge_to != r_q || r_cur == '0) begin
                    n_state = S_ALINKP;
                end
            end
            S_ALINKP: n_state = S_OUT;
            S_QWALK: begin
                if (edge_to != '0 || r_cur == '0) begin
                    n_state = S_QFIN;
                end
            end
            S_QFIN: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and table accesses
    // ------------------------------------------------------------------
    always_comb begin
        t_row wrow;

        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        wrow       = rd_row;

        n_count    = r_count;
        n_last     = r_last;
        n_last_len = r_last_len;
        n_p        = r_p;
        n_plen     = r_plen;
        n_cur      = r_cur;
        n_cur_len  = r_cur_len;
        n_q        = r_q;
        n_r        = r_r;
        n_link     = r_link;
        n_mstate   = r_mstate;
        n_cm       = r_cm;
        n_long     = r_long;
        n_lstart   = r_lstart;
        n_qpos     = r_qpos;
        n_first    = r_first;
        n_status   = r_status;

        unique case (r_state)
            S_INIT: begin
                // root row: no transitions, depth zero
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '0;
            end
            S_IDLE: ;
            S_DISP: begin
                n_status = 1'b0;
                unique case (r_op)
                    OP_CLEAR: ;
                    OP_APPEND: begin
                        if (letter_ok) begin
                            if (full) begin
                                n_status = 1'b1;
                            end else begin
                                // allocate the new last state, start walk at old last
                                mem_we         = 1'b1;
                                mem_waddr      = r_count[ST_W-1:0];
                                mem_wdata      = '0;
                                mem_wdata.len  = r_last_len + LEN_W'(1);
                                mem_re         = 1'b1;
                                mem_raddr      = r_last;
                                n_p            = r_count[ST_W-1:0];
                                n_plen         = r_last_len + LEN_W'(1);
                                n_count        = r_count + COUNT_W'(1);
                                n_cur          = r_last;
                            end
                        end
                    end
                    OP_QUERY: begin
                        if (letter_ok) begin
                            mem_re    = 1'b1;
                            mem_raddr = r_mstate;
                            n_cur     = r_mstate;
                            n_first   = 1'b1;
                        end else begin
                            n_mstate = '0;
                            n_cm     = '0;
                        end
                    end
                    default: ;
                endcase
            end
            S_CLR: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '0;
                n_count    = COUNT_W'(1);
                n_last     = '0;
                n_last_len = '0;
                n_mstate   = '0;
                n_cm       = '0;
                n_long     = '0;
                n_lstart   = '0;
                n_qpos     = '0;
            end
            S_AWALK: begin
                if (edge_to != '0) begin
                    // found an existing edge: fetch its target q
                    n_q       = edge_to;
                    n_cur_len = rd_row.len;
                    mem_re    = 1'b1;
                    mem_raddr = edge_to;
                end else begin
                    wrow.nxt[r_letter] = r_p;
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = wrow;
                    if (r_cur == '0) begin
                        n_link = '0;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_row.link;
                        n_cur     = rd_row.link;
                    end
                end
            end
            S_AQ: begin
                if (rd_row.len == r_cur_len + LEN_W'(1)) begin
                    n_link = r_q;
                end else begin
                    // clone q into a fresh row at depth cur + 1
                    wrow.len  = r_cur_len + LEN_W'(1);
                    mem_we    = 1'b1;
                    mem_waddr = r_count[ST_W-1:0];
                    mem_wdata = wrow;
                    n_r       = r_count[ST_W-1:0];
                    n_count   = r_count + COUNT_W'(1);
                end
            end
            S_AQLINK: begin
                // q now links to the clone; re-read cur to redirect edges
                wrow.link = r_r;
                mem_we    = 1'b1;
                mem_waddr = r_q;
                mem_wdata = wrow;
                mem_re    = 1'b1;
                mem_raddr = r_cur;
            end
            S_ARWALK: begin
                if (edge_to != r_q) begin
                    n_link = r_r;
                end else begin
                    wrow.nxt[r_letter] = r_r;
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = wrow;
                    if (r_cur == '0) begin
                        n_link = r_r;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_row.link;
                        n_cur     = rd_row.link;
                    end
                end
            end
            S_ALINKP: begin
                mem_we         = 1'b1;
                mem_waddr      = r_p;
                mem_wdata      = '0;
                mem_wdata.len  = r_plen;
                mem_wdata.link = r_link;
                n_last         = r_p;
                n_last_len     = r_plen;
                // an accepted append restarts query tracking
                n_mstate       = '0;
                n_cm           = '0;
                n_long         = '0;
                n_lstart       = '0;
                n_qpos         = '0;
            end
            S_QWALK: begin
                priority if (edge_to != '0) begin
                    n_cm     = r_first ? (r_cm + LEN_W'(1)) : (rd_row.len + LEN_W'(1));
                    n_mstate = edge_to;
                end else if (r_cur == '0) begin
                    n_cm     = '0;
                    n_mstate = '0;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_row.link;
                    n_cur     = rd_row.link;
                    n_first   = 1'b0;
                end
            end
            S_QFIN: begin
                if (new_best) begin
                    n_long = r_cm;
                    // start = position + 1 - length, clamped at zero
                    if ((POS_W+1)'(r_cm) > pos_next) begin
                        n_lstart = '0;
                    end else begin
                        n_lstart = POS_W'(pos_next - (POS_W+1)'(r_cm));
                    end
                end
                if (r_qpos < POS_MAX) begin
                    n_qpos = pos_next[POS_W-1:0];
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_count    <= COUNT_W'(1);
            r_last     <= '0;
            r_last_len <= '0;
            r_mstate   <= '0;
            r_cm       <= '0;
            r_long     <= '0;
            r_lstart   <= '0;
            r_qpos     <= '0;
            r_status   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_last     <= n_last;
            r_last_len <= n_last_len;
            r_mstate   <= n_mstate;
            r_cm       <= n_cm;
            r_long     <= n_long;
            r_lstart   <= n_lstart;
            r_qpos     <= n_qpos;
            r_status   <= n_status;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload and walk registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in.op;
            r_letter <= i_in.letter;
        end
        r_p       <= n_p;
        r_plen    <= n_plen;
        r_cur     <= n_cur;
        r_cur_len <= n_cur_len;
        r_q       <= n_q;
        r_r       <= n_r;
        r_link    <= n_link;
        r_first   <= n_first;
        if (out_load) begin
            r_ostatus <= r_status;
            r_omatch  <= r_cm;
            r_obest   <= r_long;
            r_ostart  <= r_lstart;
        end
    end

    // Output register: hold the transfer until the sink takes it
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ostatus;
    assign o_out.match_length = r_omatch;
    assign o_out.best_length  = r_obest;
    assign o_out.best_start   = r_ostart;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(NSTATES))
        else $error("state count beyond table");

    a_best_covers_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cm <= r_long))
        else $error("best length below current match");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !mem_we)
        else $error("table written while no item is in work");

    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP && r_op == OP_APPEND && letter_ok && full)
            |=> (r_count == $past(r_count)))
        else $error("refused append changed state count");
endmodule

// File: rtl/sacs_row_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// sacs_row_ram: simple dual-port RAM
// One write port and one read port, read data registered and held.
// ============================================================================
module sacs_row_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
